FILE: src/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types and constants for the block pool free list allocator.
// ----------------------------------------------------------------------------
package bpfl_pkg;

  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 7'd127;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 7'd59;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic sweep;
    logic do_free;
    logic do_fail;
    logic do_alloc;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic list_empty;
    logic out_free;
  } status_t;

endpackage

FILE: src/block_pool_fifo_free_list.sv
// ----------------------------------------------------------------------------
// block_pool_fifo_free_list
// Fixed pool of BLOCKS equal blocks on a linked FIFO free list: allocate
// takes the head block, free appends at the rear.
//
//   channel | direction | handshake            | payload
//   in      | to block  | in_valid / in_stall  | kind, block_index
//   out     | from block| out_valid / out_stall| ok, given_index, space_busy,
//           |           |                      | blocks_in_use
//   cfg     | to block  | cfg_write            | cfg_data (busy threshold)
//
// A free or a refused allocate is carried out straight from the idle state; a
// granted allocate passes through a lookup state, needed for the registered read
// of the link table at the head pointer, and holds in_stall high during it.
// After rst the link table is swept one entry a cycle, over all BLOCKS entries,
// with in_stall held high; cfg writes are taken during the sweep.
// One result register sits on the output; a new beat is taken while it is
// being drained, and in_stall rises while it is full and stalled.
// ----------------------------------------------------------------------------
module block_pool_fifo_free_list #(
  parameter int BLOCKS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [bpfl_pkg::IDX_W-1:0]   block_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [bpfl_pkg::IDX_W-1:0]   given_index,
  output logic                         space_busy,
  output logic [bpfl_pkg::COUNT_W-1:0] blocks_in_use,
  input  logic                         cfg_write,
  input  logic [bpfl_pkg::COUNT_W-1:0] cfg_data
);

  bpfl_pkg::cmd_t    cmd;
  bpfl_pkg::status_t status;

  bpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  bpfl_datapath #(
    .BLOCKS (BLOCKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .block_index   (block_index),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .given_index   (given_index),
    .space_busy    (space_busy),
    .blocks_in_use (blocks_in_use)
  );

endmodule

FILE: src/bpfl_ctrl.sv
// ----------------------------------------------------------------------------
// bpfl_ctrl
// Sequencer: link table sweep after reset, input beat acceptance and the
// lookup state that a granted allocate passes through for the link read.
// ----------------------------------------------------------------------------
module bpfl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  bpfl_pkg::status_t status,
  output bpfl_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT   = 3'b001,
    S_IDLE   = 3'b010,
    S_LOOKUP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind == bpfl_pkg::KIND_FREE) begin
            cmd.do_free = 1'b1;
          end else if (status.list_empty) begin
            cmd.do_fail = 1'b1;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        cmd.do_alloc = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  a_accept_after_sweep: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE) && !status.sweep_done == 1'b0 || !accept)
    else $error("beat accepted before link sweep finished");

  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) |=> (state == S_IDLE))
    else $error("lookup held longer than one cycle");

  a_alloc_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.do_alloc |-> $past(accept) && ($past(kind) == bpfl_pkg::KIND_ALLOC))
    else $error("allocate issued without an accepted allocate beat");

endmodule

FILE: src/bpfl_datapath.sv
// ----------------------------------------------------------------------------
// bpfl_datapath
// Link table, head/rear pointers, in-use count, busy flag, threshold
// register and the output register.
// ----------------------------------------------------------------------------
module bpfl_datapath #(
  parameter int BLOCKS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bpfl_pkg::cmd_t                   cmd,
  output bpfl_pkg::status_t                status,
  input  logic [bpfl_pkg::IDX_W-1:0]       block_index,
  input  logic                             cfg_write,
  input  logic [bpfl_pkg::COUNT_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             ok,
  output logic [bpfl_pkg::IDX_W-1:0]       given_index,
  output logic                             space_busy,
  output logic [bpfl_pkg::COUNT_W-1:0]     blocks_in_use
);

  localparam int IW = $clog2(BLOCKS);

  logic [IW-1:0] link_mem [BLOCKS];
  logic [IW-1:0] link_rd;

  logic [IW-1:0] sweep_ptr;
  logic [IW-1:0] head;
  logic [IW-1:0] rear;
  logic          list_empty;
  logic [bpfl_pkg::COUNT_W-1:0] used_count;
  logic          busy_flag;
  logic [bpfl_pkg::COUNT_W-1:0] threshold;

  logic          in_range;
  logic [IW-1:0] free_idx;
  logic [bpfl_pkg::COUNT_W-1:0] count_inc;
  logic [bpfl_pkg::COUNT_W-1:0] count_dec;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;
  logic          load;
  logic          sweep_last;

  assign sweep_last = (sweep_ptr == IW'(BLOCKS - 1));
  assign in_range   = (32'(block_index) < 32'(BLOCKS));
  assign free_idx   = IW'(block_index);
  assign count_inc  = (used_count == bpfl_pkg::COUNT_MAX) ? used_count
                                                          : used_count + 7'd1;
  assign count_dec  = (used_count == '0) ? used_count : used_count - 7'd1;

  assign status.sweep_done = sweep_last;
  assign status.list_empty = list_empty;
  assign status.out_free   = !out_valid || !out_stall;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_ptr;
    mem_wdata = sweep_last ? '0 : sweep_ptr + IW'(1);
    if (cmd.sweep) begin
      mem_we = 1'b1;
    end else if (cmd.do_free && in_range && !list_empty) begin
      mem_we    = 1'b1;
      mem_waddr = rear;
      mem_wdata = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rd <= link_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr  <= '0;
      head       <= '0;
      rear       <= IW'(BLOCKS - 1);
      list_empty <= 1'b0;
      used_count <= '0;
      busy_flag  <= 1'b0;
      threshold  <= bpfl_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg_write) begin
        threshold <= cfg_data;
      end
      if (cmd.sweep && !sweep_last) begin
        sweep_ptr <= sweep_ptr + IW'(1);
      end
      if (cmd.do_free && in_range) begin
        rear       <= free_idx;
        used_count <= count_dec;
        if (list_empty) begin
          head       <= free_idx;
          list_empty <= 1'b0;
        end
      end
      if (cmd.do_alloc) begin
        used_count <= count_inc;
        busy_flag  <= (count_inc > threshold);
        if (head == rear) begin
          list_empty <= 1'b1;
        end else begin
          head <= link_rd;
        end
      end
    end
  end

  assign load = cmd.do_free || cmd.do_fail || cmd.do_alloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      priority if (cmd.do_alloc) begin
        ok            <= 1'b1;
        given_index   <= bpfl_pkg::IDX_W'(head);
        space_busy    <= (count_inc > threshold);
        blocks_in_use <= count_inc;
      end else if (cmd.do_free && in_range) begin
        ok            <= 1'b1;
        given_index   <= '0;
        space_busy    <= busy_flag;
        blocks_in_use <= count_dec;
      end else begin
        ok            <= 1'b0;
        given_index   <= '0;
        space_busy    <= busy_flag;
        blocks_in_use <= used_count;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result overwrote a beat still waiting");

  a_alloc_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.do_alloc |-> !list_empty)
    else $error("allocate from an empty list");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sweep, cmd.do_free, cmd.do_fail, cmd.do_alloc}))
    else $error("conflicting datapath commands");

endmodule

FILE: verif/block_pool_fifo_free_list_tb.sv
// ----------------------------------------------------------------------------
// block_pool_fifo_free_list_tb
// Self-checking bench for the block pool free list allocator. A cycle-free
// model of the pool (link table, head, rear, in-use count, busy flag) predicts
// every reply as each beat is taken. A monitor compares each reply beat with
// the oldest prediction. Directed tests drain and refill the pool and sweep the
// busy threshold. Random tests run mostly legal alloc/free traffic, then
// double frees. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module block_pool_fifo_free_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_BLOCKS = 64;
  localparam int IDX_W       = bpfl_pkg::IDX_W;
  localparam int COUNT_W     = bpfl_pkg::COUNT_W;

  typedef struct packed {
    logic               ok;
    logic [IDX_W-1:0]   given_index;
    logic               space_busy;
    logic [COUNT_W-1:0] blocks_in_use;
  } pool_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = bpfl_pkg::KIND_ALLOC;
  logic [IDX_W-1:0]   block_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [IDX_W-1:0]   given_index;
  logic               space_busy;
  logic [COUNT_W-1:0] blocks_in_use;
  logic               cfg_write = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  block_pool_fifo_free_list #(.BLOCKS(POOL_BLOCKS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .block_index  (block_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .given_index  (given_index),
    .space_busy   (space_busy),
    .blocks_in_use(blocks_in_use),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool model
  logic [IDX_W-1:0]   link_tbl [POOL_BLOCKS];
  logic [IDX_W-1:0]   head_blk;
  logic [IDX_W-1:0]   rear_blk;
  logic               pool_empty;
  logic [COUNT_W-1:0] in_use;
  logic               busy;
  logic [COUNT_W-1:0] threshold;

  pool_reply_t        predicted_replies [$];
  logic [IDX_W-1:0]   held_blocks [$];
  pool_reply_t        want;
  pool_reply_t        got_reply;

  int errors = 0;
  int n_grant = 0;
  int n_refuse = 0;
  int n_free = 0;
  int n_busy_hi = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  int stall_pct = 0;
  int cycle_cnt = 0;

  task automatic pool_apply(input logic k, input logic [IDX_W-1:0] idx);
    pool_reply_t r;
    int j;
    r = '0;
    if (k == bpfl_pkg::KIND_ALLOC) begin
      if (pool_empty) begin
        n_refuse++;
      end else begin
        r.ok = 1'b1;
        r.given_index = head_blk;
        if (head_blk == rear_blk) pool_empty = 1'b1;
        else head_blk = link_tbl[head_blk];
        if (in_use < bpfl_pkg::COUNT_MAX) in_use++;
        busy = in_use > threshold;
        held_blocks.push_back(r.given_index);
        n_grant++;
      end
    end else begin
      r.ok = 1'b1;
      if (pool_empty) begin
        head_blk = idx;
        rear_blk = idx;
        pool_empty = 1'b0;
      end else begin
        link_tbl[rear_blk] = idx;
        rear_blk = idx;
      end
      if (in_use != 0) in_use--;
      for (j = 0; j < held_blocks.size(); j++) begin
        if (held_blocks[j] == idx) begin
          held_blocks.delete(j);
          break;
        end
      end
      n_free++;
    end
    r.space_busy = busy;
    r.blocks_in_use = in_use;
    if (busy) n_busy_hi++;
    predicted_replies.push_back(r);
  endtask

  task automatic issue_beat(input logic k, input logic [IDX_W-1:0] idx);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b1;
    kind <= k;
    block_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    pool_apply(k, idx);
  endtask

  task automatic alloc_beat();
    issue_beat(bpfl_pkg::KIND_ALLOC, IDX_W'($urandom_range(POOL_BLOCKS - 1)));
  endtask

  task automatic free_held();
    issue_beat(bpfl_pkg::KIND_FREE,
               held_blocks[$urandom_range(held_blocks.size() - 1)]);
  endtask

  task automatic free_all();
    while (held_blocks.size() != 0) free_held();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [COUNT_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    threshold = v;
    cfg_write <= 1'b0;
  endtask

  task automatic mixed_beat(input int alloc_pct);
    if (held_blocks.size() == 0 || $urandom_range(99) < alloc_pct) alloc_beat();
    else free_held();
  endtask

  task automatic test_fill_and_refuse();
    gaps_on = 1'b0;
    repeat (POOL_BLOCKS + 2) alloc_beat();
    issue_beat(bpfl_pkg::KIND_FREE, 6'd5);
    alloc_beat();
    alloc_beat();
    free_all();
  endtask

  task automatic test_threshold_extremes();
    settle();
    set_threshold(7'd0);
    alloc_beat();
    alloc_beat();
    free_held();
    free_all();
    settle();
    set_threshold(7'd127);
    alloc_beat();
    free_all();
    settle();
    set_threshold(7'd64);
    gaps_on = 1'b1;
    repeat (POOL_BLOCKS + 1) alloc_beat();
    free_all();
    settle();
    set_threshold(bpfl_pkg::THRESHOLD_RESET);
  endtask

  task automatic test_random_traffic();
    int alloc_pct [5];
    logic [COUNT_W-1:0] thr [5];
    alloc_pct = '{75, 50, 25, 60, 40};
    thr[0] = bpfl_pkg::THRESHOLD_RESET;
    thr[1] = COUNT_W'($urandom_range(40, 63));
    thr[2] = COUNT_W'($urandom_range(1, 20));
    thr[3] = 7'd63;
    thr[4] = COUNT_W'($urandom_range(127));
    for (int p = 0; p < 5; p++) begin
      settle();
      set_threshold(thr[p]);
      gaps_on = (p != 0);
      repeat (180) mixed_beat(alloc_pct[p]);
    end
  endtask

  task automatic test_double_free();
    settle();
    set_threshold(COUNT_W'($urandom_range(30, 64)));
    gaps_on = 1'b1;
    free_all();
    issue_beat(bpfl_pkg::KIND_FREE, 6'd63);
    issue_beat(bpfl_pkg::KIND_FREE, 6'd63);
    issue_beat(bpfl_pkg::KIND_FREE, 6'd0);
    repeat (300) begin
      if ($urandom_range(99) < 15)
        issue_beat(bpfl_pkg::KIND_FREE, IDX_W'($urandom_range(POOL_BLOCKS - 1)));
      else
        mixed_beat(55);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_reply = {ok, given_index, space_busy, blocks_in_use};
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected reply beat ok=%0d idx=%0d busy=%0d used=%0d",
                   $time, ok, given_index, space_busy, blocks_in_use);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (got_reply !== want) begin
            $display("%0t: reply mismatch expected ok=%0d idx=%0d busy=%0d used=%0d",
                     $time, want.ok, want.given_index, want.space_busy,
                     want.blocks_in_use);
            $display("%0t:                  actual ok=%0d idx=%0d busy=%0d used=%0d",
                     $time, ok, given_index, space_busy, blocks_in_use);
            errors++;
          end
        end
      end
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < POOL_BLOCKS; i++) link_tbl[i] = IDX_W'((i + 1) % POOL_BLOCKS);
    head_blk = '0;
    rear_blk = IDX_W'(POOL_BLOCKS - 1);
    pool_empty = 1'b0;
    in_use = '0;
    busy = 1'b0;
    threshold = bpfl_pkg::THRESHOLD_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_refuse();
    test_threshold_extremes();
    test_random_traffic();
    test_double_free();
    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d beats: %0d grants, %0d refusals on an empty pool, %0d frees,",
             n_grant + n_refuse + n_free, n_grant, n_refuse, n_free);
    $display("busy high on %0d replies; thresholds 0, 59, 63, 64, 127 and random values",
             n_busy_hi);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/bpfl_pkg.sv
src/bpfl_ctrl.sv
src/bpfl_datapath.sv
src/block_pool_fifo_free_list.sv
verif/block_pool_fifo_free_list_tb.sv
